FILE: rtl/bmm_pkg.sv
package bmm_pkg;

    localparam int MAX_DIM = 16;
    localparam int ELEM_BITS = 16;

    localparam int DIM_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    // stored elements never exceed the 16-bit input field
    localparam int STORE_BITS = (ELEM_BITS < 16) ? ELEM_BITS : 16;
    localparam int PROD_BITS = 2 * STORE_BITS;
    localparam int ADDR_BITS = 3 * DIM_BITS;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;

    localparam int IDX_BITS = 4;
    localparam int SIZE_BITS = 5;
    localparam int CMP_BITS = 8;
    localparam int VALUE_BITS = 16;
    localparam int RESULT_BITS = 36;
    localparam int CFG_IDX_BITS = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ACT_LOAD_FIRST = 2'd0;
    localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [1:0] ACT_REQUEST = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SLICE_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INNER_SIZE = 2'd2;

    typedef enum logic [2:0] {
        KIND_LOAD_FIRST,
        KIND_LOAD_SECOND,
        KIND_IGNORE,
        KIND_FLAG,
        KIND_MAC
    } kind_t;

    typedef struct packed {
        kind_t                        kind;
        logic [DIM_BITS-1:0]          slice;
        logic [DIM_BITS-1:0]          row;
        logic [DIM_BITS-1:0]          col;
        logic [DIM_BITS-1:0]          last;
        logic signed [STORE_BITS-1:0] value;
    } job_t;

    function automatic logic [DIM_BITS-1:0] to_dim(input logic [IDX_BITS-1:0] idx);
        logic [CMP_BITS-1:0] w;
        w = CMP_BITS'(idx);
        return w[DIM_BITS-1:0];
    endfunction

    function automatic logic [CMP_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] v);
        logic [CMP_BITS-1:0] w;
        w = CMP_BITS'(v);
        if (w > CMP_BITS'(MAX_DIM))
        begin
            w = CMP_BITS'(MAX_DIM);
        end
        return w;
    endfunction

endpackage

FILE: rtl/batched_matrix_multiply.sv
// Batched matrix product, one result element per request. The front accepts an item whenever
// the two-entry queue has room, checks its indices against the configured sizes and queues it;
// action code 3 is taken and dropped with no result. The back takes one queued item at a time:
// a load writes its store if its indices are in range and returns a result of zero, an
// out-of-range request returns status 1, and an in-range request runs through the single
// read port of each element store feeding one multiply-accumulate per cycle, then the registered
// read, the product register and the final add. Both stores are plain memories
// with no clearing after reset; an entry must be loaded before a request reads it.
module batched_matrix_multiply (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bmm_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [bmm_pkg::SIZE_BITS-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             action,
    input  logic [bmm_pkg::IDX_BITS-1:0]           slice_index,
    input  logic [bmm_pkg::IDX_BITS-1:0]           row_index,
    input  logic [bmm_pkg::IDX_BITS-1:0]           col_index,
    input  logic signed [bmm_pkg::VALUE_BITS-1:0]  element_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [bmm_pkg::RESULT_BITS-1:0] product_value,
    output logic                                   status
);

    logic q_full;
    logic push;
    logic pop;
    logic q_valid;
    bmm_pkg::job_t push_job;
    bmm_pkg::job_t head;

    bmm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .slice_index   (slice_index),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .q_full        (q_full),
        .push          (push),
        .job           (push_job)
    );

    bmm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    bmm_exec u_exec (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .product_value (product_value),
        .status        (status)
    );

endmodule

FILE: rtl/bmm_front.sv
module bmm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bmm_pkg::SIZE_BITS-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic [bmm_pkg::IDX_BITS-1:0]       slice_index,
    input  logic [bmm_pkg::IDX_BITS-1:0]       row_index,
    input  logic [bmm_pkg::IDX_BITS-1:0]       col_index,
    input  logic signed [bmm_pkg::VALUE_BITS-1:0] element_value,
    input  logic                               q_full,
    output logic                               push,
    output bmm_pkg::job_t                      job
);

    logic [bmm_pkg::SIZE_BITS-1:0] slice_count_reg;
    logic [bmm_pkg::SIZE_BITS-1:0] row_count_reg;
    logic [bmm_pkg::SIZE_BITS-1:0] inner_size_reg;

    logic [bmm_pkg::CMP_BITS-1:0] ns;
    logic [bmm_pkg::CMP_BITS-1:0] nr;
    logic [bmm_pkg::CMP_BITS-1:0] ni;
    logic [bmm_pkg::CMP_BITS-1:0] ni_m1;
    logic s_ok;
    logic r_ok;
    logic r_inner_ok;
    logic c_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= bmm_pkg::SIZE_BITS'(1);
            row_count_reg   <= bmm_pkg::SIZE_BITS'(1);
            inner_size_reg  <= bmm_pkg::SIZE_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bmm_pkg::CFG_SLICE_COUNT: slice_count_reg <= cfg_data;
                bmm_pkg::CFG_ROW_COUNT:   row_count_reg <= cfg_data;
                bmm_pkg::CFG_INNER_SIZE:  inner_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ns = bmm_pkg::eff_size(slice_count_reg);
        nr = bmm_pkg::eff_size(row_count_reg);
        ni = bmm_pkg::eff_size(inner_size_reg);
        ni_m1 = ni - bmm_pkg::CMP_BITS'(1);
        s_ok = bmm_pkg::CMP_BITS'(slice_index) < ns;
        r_ok = bmm_pkg::CMP_BITS'(row_index) < nr;
        r_inner_ok = bmm_pkg::CMP_BITS'(row_index) < ni;
        c_ok = bmm_pkg::CMP_BITS'(col_index) < ni;

        job.slice = bmm_pkg::to_dim(slice_index);
        job.row   = bmm_pkg::to_dim(row_index);
        job.col   = bmm_pkg::to_dim(col_index);
        // only meaningful for accepted requests, where inner size is at least one
        job.last  = ni_m1[bmm_pkg::DIM_BITS-1:0];
        job.value = element_value[bmm_pkg::STORE_BITS-1:0];

        unique case (action)
            bmm_pkg::ACT_LOAD_FIRST:
                job.kind = (s_ok && r_ok && c_ok) ? bmm_pkg::KIND_LOAD_FIRST
                                                   : bmm_pkg::KIND_IGNORE;
            bmm_pkg::ACT_LOAD_SECOND:
                job.kind = (s_ok && r_inner_ok && c_ok) ? bmm_pkg::KIND_LOAD_SECOND
                                                         : bmm_pkg::KIND_IGNORE;
            bmm_pkg::ACT_REQUEST:
                job.kind = (s_ok && r_ok && c_ok) ? bmm_pkg::KIND_MAC
                                                   : bmm_pkg::KIND_FLAG;
            bmm_pkg::ACT_UNUSED:
                job.kind = bmm_pkg::KIND_IGNORE;
        endcase
    end

    // unused action is consumed with no item queued
    assign in_stall = q_full;
    assign push = in_valid && !q_full && (action != bmm_pkg::ACT_UNUSED);

endmodule

FILE: rtl/bmm_queue.sv
module bmm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bmm_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output bmm_pkg::job_t head
);

    bmm_pkg::job_t entry_reg [bmm_pkg::QUEUE_DEPTH];
    logic [bmm_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [bmm_pkg::QPTR_BITS-1:0] wr_ptr_next;
    logic [bmm_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [bmm_pkg::QPTR_BITS-1:0] rd_ptr_next;
    logic [bmm_pkg::QCNT_BITS-1:0] count_reg;
    logic [bmm_pkg::QCNT_BITS-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign full = (count_reg == bmm_pkg::QCNT_BITS'(bmm_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == bmm_pkg::QPTR_BITS'(bmm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == bmm_pkg::QPTR_BITS'(bmm_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/bmm_exec.sv
module bmm_exec (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  bmm_pkg::job_t                          head,
    output logic                                   pop,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [bmm_pkg::RESULT_BITS-1:0] product_value,
    output logic                                   status
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic signed [bmm_pkg::STORE_BITS-1:0] first_mem [bmm_pkg::STORE_DEPTH];
    logic signed [bmm_pkg::STORE_BITS-1:0] second_mem [bmm_pkg::STORE_DEPTH];

    logic state_reg;
    logic issue_reg;
    logic rd_v_reg;
    logic rd_last_reg;
    logic mul_v_reg;
    logic mul_last_reg;
    logic out_valid_reg;

    logic [bmm_pkg::DIM_BITS-1:0] slice_reg;
    logic [bmm_pkg::DIM_BITS-1:0] row_reg;
    logic [bmm_pkg::DIM_BITS-1:0] col_reg;
    logic [bmm_pkg::DIM_BITS-1:0] last_reg;
    logic [bmm_pkg::DIM_BITS-1:0] l_reg;

    logic signed [bmm_pkg::STORE_BITS-1:0]  a_q_reg;
    logic signed [bmm_pkg::STORE_BITS-1:0]  b_q_reg;
    logic signed [bmm_pkg::PROD_BITS-1:0]   prod_reg;
    logic signed [bmm_pkg::RESULT_BITS-1:0] acc_reg;
    logic signed [bmm_pkg::RESULT_BITS-1:0] acc_next;
    logic signed [bmm_pkg::RESULT_BITS-1:0] prod_ext;
    logic signed [bmm_pkg::RESULT_BITS-1:0] product_reg;
    logic status_reg;

    logic [bmm_pkg::ADDR_BITS-1:0] a_raddr;
    logic [bmm_pkg::ADDR_BITS-1:0] b_raddr;
    logic [bmm_pkg::ADDR_BITS-1:0] waddr;
    logic out_free;
    logic issue_last;
    logic finish;
    logic load_now;
    logic start_mac;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop = (state_reg == ST_IDLE) && q_valid && out_free;
    assign start_mac = pop && (head.kind == bmm_pkg::KIND_MAC);
    assign load_now = pop && (head.kind != bmm_pkg::KIND_MAC);
    assign issue_last = issue_reg && (l_reg == last_reg);
    assign finish = mul_v_reg && mul_last_reg;

    assign a_raddr = {slice_reg, row_reg, l_reg};
    assign b_raddr = {slice_reg, l_reg, col_reg};
    assign waddr = {head.slice, head.row, head.col};

    assign prod_ext = bmm_pkg::RESULT_BITS'(prod_reg);
    assign acc_next = acc_reg + prod_ext;

    always_ff @(posedge clk)
    begin
        if (pop && (head.kind == bmm_pkg::KIND_LOAD_FIRST))
        begin
            first_mem[waddr] <= head.value;
        end
        if (pop && (head.kind == bmm_pkg::KIND_LOAD_SECOND))
        begin
            second_mem[waddr] <= head.value;
        end
        a_q_reg <= first_mem[a_raddr];
        b_q_reg <= second_mem[b_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issue_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            rd_last_reg <= 1'b0;
            mul_v_reg <= 1'b0;
            mul_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= issue_reg;
            rd_last_reg <= issue_last;
            mul_v_reg <= rd_v_reg;
            mul_last_reg <= rd_last_reg;
            if (issue_last)
            begin
                issue_reg <= 1'b0;
            end
            if (start_mac)
            begin
                state_reg <= ST_BUSY;
                issue_reg <= 1'b1;
            end
            else if (finish)
            begin
                state_reg <= ST_IDLE;
            end
            if (load_now || finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_q_reg * b_q_reg;
        if (start_mac)
        begin
            slice_reg <= head.slice;
            row_reg <= head.row;
            col_reg <= head.col;
            last_reg <= head.last;
            l_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (issue_reg)
            begin
                l_reg <= l_reg + 1'b1;
            end
            if (mul_v_reg)
            begin
                acc_reg <= acc_next;
            end
        end
        if (finish)
        begin
            product_reg <= acc_next;
            status_reg <= 1'b0;
        end
        else if (load_now)
        begin
            product_reg <= '0;
            unique case (head.kind)
                bmm_pkg::KIND_FLAG:        status_reg <= 1'b1;
                bmm_pkg::KIND_LOAD_FIRST,
                bmm_pkg::KIND_LOAD_SECOND,
                bmm_pkg::KIND_IGNORE,
                bmm_pkg::KIND_MAC:         status_reg <= 1'b0;
                default:                   status_reg <= 1'b0;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign product_value = product_reg;
    assign status = status_reg;

endmodule
